// ----- src/assert_macros.svh -----
// Assertion macros shared by the touch event queue RTL.
// No dependencies; expects clk_i and rst_ni in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TEQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Implication checked in the same cycle.
`define TEQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

// ----- src/teq_pkg.sv -----
// Types and constants for the touch event queue.
// No dependencies; used by teq_cell and the top level.
`timescale 1ns / 1ps
package teq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] EV_DOWN = 2'd0;
  localparam logic [1:0] EV_MOVE = 2'd1;
  localparam logic [1:0] EV_UP   = 2'd2;

  localparam logic [1:0] RD_POINT = 2'd0;
  localparam logic [1:0] RD_ERROR = 2'd2;

  localparam logic [2:0] ST_QUEUED    = 3'd0;
  localparam logic [2:0] ST_COALESCED = 3'd1;
  localparam logic [2:0] ST_RESYNC    = 3'd2;
  localparam logic [2:0] ST_OVERFLOW  = 3'd3;
  localparam logic [2:0] ST_ERROR     = 3'd4;
  localparam logic [2:0] ST_IGNORED   = 3'd5;

  localparam logic KIND_OFFER = 1'b0;

  typedef struct packed {
    logic        kind;
    logic [1:0]  read_status;
    logic [11:0] point_x;
    logic [11:0] point_y;
    logic [31:0] stamp_us;
  } req_t;

  typedef struct packed {
    logic [2:0]  offer_status;
    logic        event_valid;
    logic [11:0] event_x;
    logic [11:0] event_y;
    logic [31:0] event_time;
    logic [31:0] event_seq;
    logic [1:0]  event_type;
    logic [4:0]  pending_count;
  } res_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [1:0]  kind;
    logic [31:0] time_us;
    logic [31:0] seq;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHIFT,
    OP_DROP,
    OP_WRITE
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] widx;
    logic [CNT_W-1:0] count;
    entry_t           wdata;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_APPEND2
  } state_e;

endpackage

// ----- src/teq_cell.sv -----
// One queue cell: holds one event, takes its upper neighbor on shift or drop.
// Depends on teq_pkg.
`timescale 1ns / 1ps
module teq_cell (
  input  logic                        clk_i,
  input  teq_pkg::cmd_t               cmd_i,
  input  logic [teq_pkg::IDX_W-1:0]   idx_i,
  input  teq_pkg::entry_t             nbr_i,
  input  logic                        found_i,
  output logic                        found_o,
  output teq_pkg::entry_t             ent_o
);

  teq_pkg::entry_t ent_q, ent_d;
  logic            valid;

  always_comb begin
    valid   = ({1'b0, idx_i} < cmd_i.count);
    // a move at or below this cell: this cell closes the gap on drop
    found_o = found_i | (valid && (ent_q.kind == teq_pkg::EV_MOVE));
    unique case (cmd_i.op)
      teq_pkg::OP_HOLD:  ent_d = ent_q;
      teq_pkg::OP_SHIFT: ent_d = nbr_i;
      teq_pkg::OP_DROP:  ent_d = found_o ? nbr_i : ent_q;
      teq_pkg::OP_WRITE: ent_d = (idx_i == cmd_i.widx) ? cmd_i.wdata : ent_q;
      default:           ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

// ----- src/touch_event_queue_coalescing_core.sv -----
// Touch event queue core: control sequencer over a row of teq_cell stages.
// Depends on teq_pkg, teq_cell and assert_macros.svh.
// Sequence: a request is accepted in S_IDLE and executed in S_EXEC; a compaction or a
//   two-event resync adds an S_APPEND2 state for the second cell write.
// Pacing: a new request is taken only in S_IDLE; the single cell write port forces the extra state.
// Reset: asynchronous, active low; queue empty, sequence 0, lift count 3; done_o never stalls.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module touch_event_queue_coalescing_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  teq_pkg::req_t  req_i,
  output logic           done_o,
  output teq_pkg::res_t  res_o,
  input  logic           cfg_we_i,
  input  logic [3:0]     cfg_wdata_i
);

  localparam int unsigned IW = teq_pkg::IDX_W;
  localparam int unsigned CW = teq_pkg::CNT_W;

  // control state
  teq_pkg::state_e   state_q, state_d;
  logic [3:0]        lcr_q;
  logic [CW-1:0]     count_q, count_d;
  logic [31:0]       seq_q, seq_d;
  logic              pd_q, pd_d;      // producer side touching
  logic              cd_q, cd_d;      // consumer side touching
  logic [3:0]        run_q, run_d;    // no-touch run length
  logic              done_q, done_d;

  // payload
  teq_pkg::req_t     req_q;
  logic [23:0]       last_xy_q, last_xy_d;
  logic [23:0]       held_pt_q, held_pt_d;
  logic [63:0]       held_ts_q, held_ts_d;
  teq_pkg::entry_t   pend_q, pend_d;  // second write of a two-step request
  logic [2:0]        stat_q, stat_d;
  teq_pkg::res_t     res_q, res_d;

  // cell row
  teq_pkg::cmd_t     cmd;
  teq_pkg::entry_t   ents [teq_pkg::DEPTH];
  logic [teq_pkg::DEPTH:0] found;

  assign found[0] = 1'b0;

  for (genvar g = 0; g < teq_pkg::DEPTH; g++) begin : g_cell
    teq_pkg::entry_t nbr;
    if (g == teq_pkg::DEPTH - 1) begin : g_last
      assign nbr = ents[g];
    end else begin : g_mid
      assign nbr = ents[g+1];
    end
    teq_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .idx_i   (IW'(g)),
      .nbr_i   (nbr),
      .found_i (found[g]),
      .found_o (found[g+1]),
      .ent_o   (ents[g])
    );
  end

  // execute-step helpers
  logic [31:0]       seq_n;
  logic [CW-1:0]     cnt_m1;
  logic [1:0]        newest_kind;
  logic              any_move;
  logic [4:0]        run_inc, run_new;
  teq_pkg::entry_t   ev;
  logic              do_put;
  logic [2:0]        put_res;
  logic [31:0]       down_seq;

  assign seq_n       = seq_q + 32'd1;
  assign cnt_m1      = count_q - CW'(1);
  assign newest_kind = ents[cnt_m1[IW-1:0]].kind;
  assign any_move    = found[teq_pkg::DEPTH];
  assign run_inc     = {1'b0, run_q} + 5'd1;
  assign run_new     = (run_inc > {1'b0, lcr_q}) ? {1'b0, lcr_q} : run_inc;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    seq_d     = seq_q;
    pd_d      = pd_q;
    cd_d      = cd_q;
    run_d     = run_q;
    last_xy_d = last_xy_q;
    held_pt_d = held_pt_q;
    held_ts_d = held_ts_q;
    pend_d    = pend_q;
    stat_d    = stat_q;
    done_d    = 1'b0;
    res_d     = res_q;
    cmd.op    = teq_pkg::OP_HOLD;
    cmd.widx  = count_q[IW-1:0];
    cmd.count = count_q;
    cmd.wdata = pend_q;
    do_put    = 1'b0;
    put_res   = teq_pkg::ST_QUEUED;
    down_seq  = seq_n;
    ev.x       = req_q.point_x;
    ev.y       = req_q.point_y;
    ev.kind    = pd_q ? teq_pkg::EV_MOVE : teq_pkg::EV_DOWN;
    ev.time_us = req_q.stamp_us;
    ev.seq     = seq_n;

    unique case (state_q)
      teq_pkg::S_IDLE: begin
        if (start) begin
          state_d = teq_pkg::S_EXEC;
        end
      end

      teq_pkg::S_EXEC: begin
        res_d = '0;
        if (req_q.kind == teq_pkg::KIND_OFFER) begin
          seq_d = seq_n;
          if (req_q.read_status == teq_pkg::RD_ERROR) begin
            put_res = teq_pkg::ST_ERROR;
          end else if (req_q.read_status == teq_pkg::RD_POINT) begin
            run_d     = '0;
            last_xy_d = {req_q.point_y, req_q.point_x};
            do_put    = 1'b1;
          end else if (!pd_q) begin
            put_res = teq_pkg::ST_IGNORED;
          end else if (run_new < {1'b0, lcr_q}) begin
            run_d   = run_new[3:0];
            put_res = teq_pkg::ST_IGNORED;
          end else begin
            // lift confirmed: up at the last point
            ev.x    = last_xy_q[11:0];
            ev.y    = last_xy_q[23:12];
            ev.kind = teq_pkg::EV_UP;
            run_d   = run_new[3:0];
            do_put  = 1'b1;
          end

          if (do_put) begin
            priority if (ev.kind == teq_pkg::EV_MOVE && count_q != '0 &&
                         newest_kind == teq_pkg::EV_MOVE) begin
              cmd.op    = teq_pkg::OP_WRITE;
              cmd.widx  = cnt_m1[IW-1:0];
              cmd.wdata = ev;
              put_res   = teq_pkg::ST_COALESCED;
            end else if (count_q == CW'(teq_pkg::DEPTH)) begin
              if (any_move) begin
                // compact out the oldest move, append next cycle
                cmd.op  = teq_pkg::OP_DROP;
                count_d = cnt_m1;
                pend_d  = ev;
                state_d = teq_pkg::S_APPEND2;
                put_res = teq_pkg::ST_QUEUED;
              end else if (ev.kind == teq_pkg::EV_MOVE) begin
                put_res = teq_pkg::ST_OVERFLOW;
              end else begin
                // resync: restart the queue, with a consistent down/up pair where one is needed
                put_res  = teq_pkg::ST_RESYNC;
                cmd.op   = teq_pkg::OP_WRITE;
                cmd.widx = '0;
                count_d  = CW'(1);
                cmd.wdata = ev;
                if (ev.kind == teq_pkg::EV_DOWN && cd_q) begin
                  cmd.wdata.x    = last_xy_q[11:0];
                  cmd.wdata.y    = last_xy_q[23:12];
                  cmd.wdata.kind = teq_pkg::EV_UP;
                  seq_d          = seq_n + 32'd1;
                  down_seq       = seq_n + 32'd1;
                  pend_d         = ev;
                  pend_d.seq     = seq_n + 32'd1;
                  state_d        = teq_pkg::S_APPEND2;
                end else if (ev.kind == teq_pkg::EV_UP && !cd_q) begin
                  cmd.wdata.x       = held_pt_q[11:0];
                  cmd.wdata.y       = held_pt_q[23:12];
                  cmd.wdata.kind    = teq_pkg::EV_DOWN;
                  cmd.wdata.time_us = held_ts_q[63:32];
                  cmd.wdata.seq     = held_ts_q[31:0];
                  pend_d            = ev;
                  state_d           = teq_pkg::S_APPEND2;
                end
              end
            end else begin
              cmd.op    = teq_pkg::OP_WRITE;
              cmd.wdata = ev;
              count_d   = count_q + CW'(1);
              put_res   = teq_pkg::ST_QUEUED;
            end

            if (put_res != teq_pkg::ST_OVERFLOW) begin
              if (ev.kind == teq_pkg::EV_DOWN) begin
                pd_d      = 1'b1;
                held_pt_d = {ev.y, ev.x};
                held_ts_d = {ev.time_us, down_seq};
              end else if (ev.kind == teq_pkg::EV_UP) begin
                pd_d  = 1'b0;
                run_d = '0;
              end
            end
          end
          res_d.offer_status = put_res;
        end else if (count_q != '0) begin
          // pop the oldest event from cell 0
          cmd.op            = teq_pkg::OP_SHIFT;
          count_d           = cnt_m1;
          res_d.event_valid = 1'b1;
          res_d.event_x     = ents[0].x;
          res_d.event_y     = ents[0].y;
          res_d.event_time  = ents[0].time_us;
          res_d.event_seq   = ents[0].seq;
          res_d.event_type  = ents[0].kind;
          if (ents[0].kind == teq_pkg::EV_DOWN) begin
            cd_d = 1'b1;
          end else if (ents[0].kind == teq_pkg::EV_UP) begin
            cd_d = 1'b0;
          end
        end
        stat_d = put_res;
        res_d.pending_count = 5'(count_d);
        if (state_d == teq_pkg::S_EXEC) begin
          state_d = teq_pkg::S_IDLE;
          done_d  = 1'b1;
        end
      end

      teq_pkg::S_APPEND2: begin
        cmd.op    = teq_pkg::OP_WRITE;
        cmd.widx  = count_q[IW-1:0];
        cmd.wdata = pend_q;
        count_d   = count_q + CW'(1);
        res_d.offer_status  = stat_q;
        res_d.pending_count = 5'(count_d);
        state_d   = teq_pkg::S_IDLE;
        done_d    = 1'b1;
      end

      default: state_d = teq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= teq_pkg::S_IDLE;
      lcr_q     <= 4'd3;
      count_q   <= '0;
      seq_q     <= '0;
      pd_q      <= 1'b0;
      cd_q      <= 1'b0;
      run_q     <= '0;
      done_q    <= 1'b0;
      last_xy_q <= '0;
      held_pt_q <= '0;
      held_ts_q <= '0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) begin
        lcr_q <= cfg_wdata_i;
      end
      count_q   <= count_d;
      seq_q     <= seq_d;
      pd_q      <= pd_d;
      cd_q      <= cd_d;
      run_q     <= run_d;
      done_q    <= done_d;
      last_xy_q <= last_xy_d;
      held_pt_q <= held_pt_d;
      held_ts_q <= held_ts_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
    pend_q <= pend_d;
    stat_q <= stat_d;
    res_q  <= res_d;
  end

  assign busy   = (state_q != teq_pkg::S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  `TEQ_ASSERT(a_count_bound, count_q <= CW'(teq_pkg::DEPTH))
  `TEQ_ASSERT_IMP(a_done_idle, done_q, state_q == teq_pkg::S_IDLE)
  `TEQ_ASSERT_IMP(a_pop_status, done_q && res_q.event_valid, res_q.offer_status == 3'd0)
  `TEQ_ASSERT_IMP(a_pending_match, done_q, res_q.pending_count == 5'(count_q))

endmodule

// ----- tb/tb_touch_event_queue_coalescing_core.sv -----
// Self-checking testbench for touch_event_queue_coalescing_core.
// Depends on teq_pkg and the core; a built-in queue model predicts each result not typed in.
`timescale 1ns / 1ps
module tb_touch_event_queue_coalescing_core;

  localparam int unsigned LIMIT_CYCLES = 300000;
  localparam int unsigned DRAIN_CYCLES = 8;
  // Read status codes the package does not name.
  localparam logic [1:0] RD_NO_TOUCH = 2'd1;
  localparam logic [1:0] RD_STALE    = 2'd3;  // decoded like a no-touch read
  localparam logic       KIND_POP    = 1'b1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  teq_pkg::req_t req_i = '0;
  logic done_o;
  teq_pkg::res_t res_o;
  logic cfg_we_i = 1'b0;
  logic [3:0] cfg_wdata_i = 4'd0;

  touch_event_queue_coalescing_core dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .done_o, .res_o, .cfg_we_i, .cfg_wdata_i
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Queue model: own copy of the event ring, touch tracking and lift setting.
  // ---------------------------------------------------------------------------
  teq_pkg::entry_t ring [teq_pkg::DEPTH];
  int unsigned     ring_head, ring_fill;
  logic [31:0]     seq_num;
  bit              prod_touching, cons_touching;
  int unsigned     quiet_run;
  logic [3:0]      lift_reads;
  logic [11:0]     last_x, last_y;
  teq_pkg::entry_t held_down;

  teq_pkg::res_t pending_results[$];
  int unsigned   mismatches, results_seen, requests_sent;
  int unsigned   status_hits[8];
  int unsigned   cycles;

  function automatic int unsigned slot(int unsigned i);
    return (ring_head + i) % teq_pkg::DEPTH;
  endfunction

  function automatic void append_event(teq_pkg::entry_t e);
    if (ring_fill >= teq_pkg::DEPTH) return;
    ring[slot(ring_fill)] = e;
    ring_fill++;
  endfunction

  // Compaction: remove the oldest move, shifting newer events toward the head.
  function automatic bit compact_oldest_move();
    for (int unsigned i = 0; i < ring_fill; i++) begin
      if (ring[slot(i)].kind != teq_pkg::EV_MOVE) continue;
      for (int unsigned j = i; j + 1 < ring_fill; j++) ring[slot(j)] = ring[slot(j + 1)];
      ring_fill--;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Full queue with no move: restart it so the consumer keeps down/up pairing.
  function automatic void resync_queue(teq_pkg::entry_t e);
    teq_pkg::entry_t t;
    ring_head = 0;
    ring_fill = 0;
    if (e.kind == teq_pkg::EV_DOWN) begin
      if (cons_touching) begin
        t = e;
        t.x = last_x;
        t.y = last_y;
        t.kind = teq_pkg::EV_UP;
        append_event(t);
        seq_num++;
        e.seq = seq_num;
      end
    end else if (!cons_touching) begin
      t = held_down;
      t.kind = teq_pkg::EV_DOWN;
      append_event(t);
    end
    append_event(e);
  endfunction

  function automatic logic [2:0] queue_event(teq_pkg::entry_t e);
    if (e.kind == teq_pkg::EV_MOVE && ring_fill != 0 &&
        ring[slot(ring_fill - 1)].kind == teq_pkg::EV_MOVE) begin
      ring[slot(ring_fill - 1)] = e;
      return teq_pkg::ST_COALESCED;
    end
    if (ring_fill >= teq_pkg::DEPTH && !compact_oldest_move()) begin
      if (e.kind == teq_pkg::EV_MOVE) return teq_pkg::ST_OVERFLOW;
      resync_queue(e);
      return teq_pkg::ST_RESYNC;
    end
    append_event(e);
    return teq_pkg::ST_QUEUED;
  endfunction

  function automatic logic [2:0] offer_read(teq_pkg::req_t r);
    teq_pkg::entry_t e;
    logic [2:0] st;
    seq_num++;
    if (r.read_status == teq_pkg::RD_ERROR) return teq_pkg::ST_ERROR;
    e.time_us = r.stamp_us;
    e.seq = seq_num;
    if (r.read_status == teq_pkg::RD_POINT) begin
      quiet_run = 0;
      e.x = r.point_x;
      e.y = r.point_y;
      e.kind = prod_touching ? teq_pkg::EV_MOVE : teq_pkg::EV_DOWN;
      st = queue_event(e);
      last_x = r.point_x;
      last_y = r.point_y;
      if (e.kind == teq_pkg::EV_DOWN && st != teq_pkg::ST_OVERFLOW && ring_fill != 0) begin
        prod_touching = 1'b1;
        held_down = ring[slot(ring_fill - 1)];
      end
      return st;
    end
    // No-touch reads only count while touching.
    if (!prod_touching) return teq_pkg::ST_IGNORED;
    quiet_run = quiet_run + 1;
    if (quiet_run > {28'd0, lift_reads}) quiet_run = {28'd0, lift_reads};
    if (quiet_run < {28'd0, lift_reads}) return teq_pkg::ST_IGNORED;
    e.x = last_x;
    e.y = last_y;
    e.kind = teq_pkg::EV_UP;
    st = queue_event(e);
    if (st != teq_pkg::ST_OVERFLOW) begin
      prod_touching = 1'b0;
      quiet_run = 0;
    end
    return st;
  endfunction

  function automatic teq_pkg::res_t predict_request(teq_pkg::req_t r);
    teq_pkg::res_t o;
    teq_pkg::entry_t e;
    o = '0;
    if (r.kind == teq_pkg::KIND_OFFER) begin
      o.offer_status = offer_read(r);
      status_hits[o.offer_status]++;
    end else if (ring_fill != 0) begin
      e = ring[ring_head];
      ring_head = (ring_head + 1) % teq_pkg::DEPTH;
      ring_fill--;
      if (e.kind == teq_pkg::EV_DOWN) cons_touching = 1'b1;
      else if (e.kind == teq_pkg::EV_UP) cons_touching = 1'b0;
      o.event_valid = 1'b1;
      o.event_x = e.x;
      o.event_y = e.y;
      o.event_time = e.time_us;
      o.event_seq = e.seq;
      o.event_type = e.kind;
    end
    o.pending_count = ring_fill[4:0];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h", results_seen, what, got, want);
  endtask

  task automatic compare_result(teq_pkg::res_t got, teq_pkg::res_t want);
    if (got.offer_status !== want.offer_status)
      report("offer_status", 32'(got.offer_status), 32'(want.offer_status));
    if (got.event_valid !== want.event_valid)
      report("event_valid", 32'(got.event_valid), 32'(want.event_valid));
    if (got.event_x !== want.event_x)
      report("event_x", 32'(got.event_x), 32'(want.event_x));
    if (got.event_y !== want.event_y)
      report("event_y", 32'(got.event_y), 32'(want.event_y));
    if (got.event_time !== want.event_time)
      report("event_time", got.event_time, want.event_time);
    if (got.event_seq !== want.event_seq) report("event_seq", got.event_seq, want.event_seq);
    if (got.event_type !== want.event_type)
      report("event_type", 32'(got.event_type), 32'(want.event_type));
    if (got.pending_count !== want.pending_count)
      report("pending_count", 32'(got.pending_count), 32'(want.pending_count));
  endtask

  // Results cannot be held off: take each one on the edge that ends its strobe.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("MISMATCH unexpected result strobe at cycle %0d", cycles);
      end else begin
        compare_result(res_o, pending_results.pop_front());
      end
      results_seen++;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("tb_touch_event_queue_coalescing_core failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving. Every task is entered right after a rising edge.
  // ---------------------------------------------------------------------------
  // Hold the request until an edge with busy low takes it, then queue the
  // prediction (or the typed-in answer) and maybe open a sender gap.
  task automatic send_request(teq_pkg::req_t r, bit typed, teq_pkg::res_t typed_res,
                              bit may_idle);
    teq_pkg::res_t p;
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    p = predict_request(r);
    pending_results.push_back(typed ? typed_res : p);
    requests_sent++;
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Lift setting changes only with the queue drained and the core settled.
  task automatic set_lift_reads(logic [3:0] v);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    lift_reads = v;
    cfg_we_i <= 1'b0;
  endtask

  function automatic teq_pkg::req_t make_req(logic k, logic [1:0] st, logic [11:0] x,
                                             logic [11:0] y, logic [31:0] ts);
    teq_pkg::req_t r;
    r.kind = k;
    r.read_status = st;
    r.point_x = x;
    r.point_y = y;
    r.stamp_us = ts;
    return r;
  endfunction

  function automatic teq_pkg::req_t random_read(logic [1:0] st);
    return make_req(teq_pkg::KIND_OFFER, st, 12'($urandom), 12'($urandom), $urandom);
  endfunction

  // Directed rows: typed answers only where they are plain (empty pops,
  // error and ignored reads on an empty queue); the rest go to the model.
  typedef struct {
    teq_pkg::req_t r;
    bit            typed;
    logic [2:0]    status;
    logic [4:0]    fill;
  } row_t;

  row_t rows[$];

  task automatic add_row(teq_pkg::req_t r, bit typed = 0,
                         logic [2:0] st = teq_pkg::ST_QUEUED, logic [4:0] fill = 0);
    row_t w;
    w.r = r;
    w.typed = typed;
    w.status = st;
    w.fill = fill;
    rows.push_back(w);
  endtask

  initial begin
    logic [3:0]    lift_plan[9];
    int unsigned   pop_pct, quiet_pct, n_items;
    bit            last_phase;
    teq_pkg::res_t typed_res;
    logic [1:0]    st;

    lift_plan = '{4'd3, 4'd0, 4'd1, 4'd15, 4'd2, 4'd7, 4'd1, 4'd0, 4'd4};
    lift_reads = 4'd3;
    ring_head = 0;
    ring_fill = 0;
    seq_num = '0;
    prod_touching = 0;
    cons_touching = 0;
    quiet_run = 0;
    last_x = '0;
    last_y = '0;
    held_down = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, at the reset lift count of three.
    add_row(make_req(KIND_POP, teq_pkg::RD_POINT, 12'd0, 12'd0, 32'd0), 1,
            teq_pkg::ST_QUEUED, 5'd0);
    add_row(make_req(teq_pkg::KIND_OFFER, teq_pkg::RD_ERROR, 12'hfff, 12'hfff, 32'hffffffff),
            1, teq_pkg::ST_ERROR, 5'd0);
    add_row(make_req(teq_pkg::KIND_OFFER, RD_NO_TOUCH, 12'd5, 12'd6, 32'd7), 1,
            teq_pkg::ST_IGNORED, 5'd0);
    add_row(make_req(teq_pkg::KIND_OFFER, RD_STALE, 12'd5, 12'd6, 32'd7), 1,
            teq_pkg::ST_IGNORED, 5'd0);
    // down, move, coalesce, error held
    add_row(make_req(teq_pkg::KIND_OFFER, teq_pkg::RD_POINT, 12'd0, 12'd0, 32'd0));
    add_row(make_req(teq_pkg::KIND_OFFER, teq_pkg::RD_POINT, 12'hfff, 12'hfff, 32'hffffffff));
    add_row(make_req(teq_pkg::KIND_OFFER, teq_pkg::RD_POINT, 12'h123, 12'h456, 32'h10));
    add_row(make_req(teq_pkg::KIND_OFFER, teq_pkg::RD_ERROR, 12'h0, 12'h0, 32'h11));
    add_row(make_req(teq_pkg::KIND_OFFER, RD_NO_TOUCH, 12'h0, 12'h0, 32'h12));
    add_row(make_req(teq_pkg::KIND_OFFER, RD_STALE, 12'h0, 12'h0, 32'h13));
    add_row(make_req(teq_pkg::KIND_OFFER, RD_NO_TOUCH, 12'h0, 12'h0, 32'h14));  // up emitted
    // last pop finds the queue empty
    repeat (4) add_row(make_req(KIND_POP, teq_pkg::RD_POINT, 12'h0, 12'h0, 32'h0));
    add_row(make_req(teq_pkg::KIND_OFFER, RD_STALE, 12'habc, 12'h543, 32'h15));  // not touching
    foreach (rows[i]) begin
      typed_res = '0;
      typed_res.offer_status = rows[i].status;
      typed_res.pending_count = rows[i].fill;
      send_request(rows[i].r, rows[i].typed, typed_res, 1'b1);
    end

    // Random phases, each at its own lift count; pops are scarce in some so
    // the queue fills and compaction, overflow and resync come up.
    foreach (lift_plan[p]) begin
      set_lift_reads(lift_plan[p]);
      last_phase = (p == $size(lift_plan) - 1);
      pop_pct = (p % 4 == 1) ? 3 : $urandom_range(5, 50);
      quiet_pct = $urandom_range(15, 55);
      n_items = 0;
      while (n_items < 185) begin
        if ($urandom_range(0, 99) < pop_pct) begin
          send_request(make_req(KIND_POP, 2'($urandom), 12'($urandom), 12'($urandom),
                                $urandom), 0, '0, !last_phase);
          n_items++;
        end else if ($urandom_range(0, 9) == 0) begin
          // A run of no-touch reads long enough to lift.
          repeat (int'(lift_plan[p]) + $urandom_range(0, 2)) begin
            send_request(random_read($urandom_range(0, 1) ? RD_NO_TOUCH : RD_STALE),
                         0, '0, !last_phase);
            n_items++;
          end
        end else begin
          if ($urandom_range(0, 99) < quiet_pct)
            st = $urandom_range(0, 4) == 0 ? RD_STALE : RD_NO_TOUCH;
          else if ($urandom_range(0, 11) == 0)
            st = teq_pkg::RD_ERROR;
          else
            st = teq_pkg::RD_POINT;
          send_request(random_read(st), 0, '0, !last_phase);
          n_items++;
        end
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests, %0d results checked; queued %0d coalesced %0d resync %0d",
             requests_sent, results_seen, status_hits[teq_pkg::ST_QUEUED],
             status_hits[teq_pkg::ST_COALESCED], status_hits[teq_pkg::ST_RESYNC]);
    $display("overflow %0d, error held %0d, ignored %0d, lift counts 0 to 15, %0d mismatches",
             status_hits[teq_pkg::ST_OVERFLOW], status_hits[teq_pkg::ST_ERROR],
             status_hits[teq_pkg::ST_IGNORED], mismatches);
    if (mismatches == 0) begin
      $display("tb_touch_event_queue_coalescing_core passed");
    end else begin
      $display("tb_touch_event_queue_coalescing_core failed");
    end
    $finish;
  end

endmodule

// ----- touch_event_queue_coalescing_core.f -----
+incdir+src
src/teq_pkg.sv
src/teq_cell.sv
src/touch_event_queue_coalescing_core.sv
tb/tb_touch_event_queue_coalescing_core.sv
